[rtl/core/dhq_pkg.sv]
// ----------------------------------------------------------------------------
// dhq_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table for
// the DH link to translation and quaternion pipeline.
// ----------------------------------------------------------------------------
package dhq_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int LENGTH_BITS   = 32;
  localparam int FRACTION_BITS = 14;
  localparam int CORDIC_STAGES = 16;

  // phase: full circle is 2^32, one guard bit for the range -2^31 .. 2^31
  localparam int PHASE_BITS = 33;
  // cordic x and y in q2.30
  localparam int XY_BITS    = 32;
  localparam int QUAT_BITS  = FRACTION_BITS + 2;

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int PROD_LAT   = 2;
  localparam int TOTAL_LAT  = CORDIC_LAT + PROD_LAT;

  localparam int TPROD_BITS = LENGTH_BITS + XY_BITS;
  localparam int TSHIFT     = 30;
  localparam int QPROD_BITS = 2 * XY_BITS;
  localparam int QSHIFT     = 60 - FRACTION_BITS;

  localparam logic signed [PHASE_BITS-1:0] PHASE_QUARTER = 33'sh0_4000_0000;
  localparam logic signed [PHASE_BITS-1:0] PHASE_HALF    = 33'sh0_8000_0000;
  localparam logic signed [XY_BITS-1:0]    CORDIC_INIT   = 32'sh26DD_3B6A;

  localparam logic signed [QUAT_BITS-1:0] QUAT_ONE     = QUAT_BITS'(1 << FRACTION_BITS);
  localparam logic signed [QUAT_BITS-1:0] QUAT_NEG_ONE = -QUAT_ONE;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_PHASE [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

[rtl/core/dhq_cordic.sv]
// ----------------------------------------------------------------------------
// dhq_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, one micro-rotation per
// stage, sign restore. Returns cosine and sine in q2.30.
// ----------------------------------------------------------------------------
module dhq_cordic import dhq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [PHASE_BITS-1:0] phase_i,
  output logic signed [XY_BITS-1:0]    cos_o,
  output logic signed [XY_BITS-1:0]    sin_o
);

  logic signed [XY_BITS-1:0]    x_q    [CORDIC_STAGES+1];
  logic signed [XY_BITS-1:0]    y_q    [CORDIC_STAGES+1];
  logic signed [PHASE_BITS-1:0] z_q    [CORDIC_STAGES+1];
  logic                         flip_q [CORDIC_STAGES+1];
  logic signed [PHASE_BITS-1:0] z_fold;
  logic                         flip;
  logic signed [XY_BITS-1:0]    cos_q, sin_q;

  // fold angles beyond a quarter turn by half a turn
  always_comb begin
    z_fold = phase_i;
    flip   = 1'b0;
    if (phase_i > PHASE_QUARTER) begin
      z_fold = phase_i - PHASE_HALF;
      flip   = 1'b1;
    end else if (phase_i < -PHASE_QUARTER) begin
      z_fold = phase_i + PHASE_HALF;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_INIT;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][PHASE_BITS-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, ATAN_PHASE[i]});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, ATAN_PHASE[i]});
        end
      end
      cos_q <= flip_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
      sin_q <= flip_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

[rtl/core/dhq_product.sv]
// ----------------------------------------------------------------------------
// dhq_product
// Multiply stage and round/saturate stage for the translation and the
// quaternion components.
// ----------------------------------------------------------------------------
module dhq_product import dhq_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [LENGTH_BITS-1:0] r_i,
  input  logic signed [XY_BITS-1:0]     ct_i,
  input  logic signed [XY_BITS-1:0]     st_i,
  input  logic signed [XY_BITS-1:0]     cht_i,
  input  logic signed [XY_BITS-1:0]     sht_i,
  input  logic signed [XY_BITS-1:0]     cha_i,
  input  logic signed [XY_BITS-1:0]     sha_i,
  output logic signed [LENGTH_BITS-1:0] trans_x_o,
  output logic signed [LENGTH_BITS-1:0] trans_y_o,
  output logic signed [QUAT_BITS-1:0]   quat_w_o,
  output logic signed [QUAT_BITS-1:0]   quat_x_o,
  output logic signed [QUAT_BITS-1:0]   quat_y_o,
  output logic signed [QUAT_BITS-1:0]   quat_z_o
);

  localparam logic signed [TPROD_BITS-1:0] T_ROUND = TPROD_BITS'(64'd1 << (TSHIFT - 1));
  localparam logic signed [TPROD_BITS-1:0] LEN_MAX =
    {{(TPROD_BITS-LENGTH_BITS+1){1'b0}}, {(LENGTH_BITS-1){1'b1}}};
  localparam logic signed [TPROD_BITS-1:0] LEN_MIN = ~LEN_MAX;
  localparam logic signed [QPROD_BITS-1:0] Q_ROUND = QPROD_BITS'(64'd1 << (QSHIFT - 1));
  localparam logic signed [QPROD_BITS-1:0] Q_MAX   = QPROD_BITS'(64'd1 << FRACTION_BITS);
  localparam logic signed [QPROD_BITS-1:0] Q_MIN   = -Q_MAX;

  function automatic logic signed [LENGTH_BITS-1:0] sat_len(
    input logic signed [TPROD_BITS-1:0] p
  );
    logic signed [TPROD_BITS-1:0] v;
    v = (p + T_ROUND) >>> TSHIFT;
    if (v > LEN_MAX) v = LEN_MAX;
    if (v < LEN_MIN) v = LEN_MIN;
    return v[LENGTH_BITS-1:0];
  endfunction

  function automatic logic signed [QUAT_BITS-1:0] clamp_quat(
    input logic signed [QPROD_BITS-1:0] p
  );
    logic signed [QPROD_BITS-1:0] v;
    v = (p + Q_ROUND) >>> QSHIFT;
    if (v > Q_MAX) v = Q_MAX;
    if (v < Q_MIN) v = Q_MIN;
    return v[QUAT_BITS-1:0];
  endfunction

  logic signed [TPROD_BITS-1:0] px_q, py_q;
  logic signed [QPROD_BITS-1:0] pw_q, pqx_q, pqy_q, pqz_q;
  logic signed [LENGTH_BITS-1:0] tx_q, ty_q;
  logic signed [QUAT_BITS-1:0]   qw_q, qx_q, qy_q, qz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= TPROD_BITS'(r_i) * TPROD_BITS'(ct_i);
      py_q  <= TPROD_BITS'(r_i) * TPROD_BITS'(st_i);
      pw_q  <= QPROD_BITS'(cha_i) * QPROD_BITS'(cht_i);
      pqx_q <= QPROD_BITS'(sha_i) * QPROD_BITS'(cht_i);
      pqy_q <= QPROD_BITS'(sha_i) * QPROD_BITS'(sht_i);
      pqz_q <= QPROD_BITS'(cha_i) * QPROD_BITS'(sht_i);
      tx_q  <= sat_len(px_q);
      ty_q  <= sat_len(py_q);
      qw_q  <= clamp_quat(pw_q);
      qx_q  <= clamp_quat(pqx_q);
      qy_q  <= clamp_quat(pqy_q);
      qz_q  <= clamp_quat(pqz_q);
    end
  end

  assign trans_x_o = tx_q;
  assign trans_y_o = ty_q;
  assign quat_w_o  = qw_q;
  assign quat_x_o  = qx_q;
  assign quat_y_o  = qy_q;
  assign quat_z_o  = qz_q;

endmodule

[rtl/core/dh_link_to_translation_quaternion.sv]
// ----------------------------------------------------------------------------
// dh_link_to_translation_quaternion
// Converts one Denavit-Hartenberg link into its translation and rotation
// quaternion through three CORDIC pipelines and a product stage.
// ----------------------------------------------------------------------------
// Takes one link transaction per clock while the output is not stalled and
// returns one result transaction for each, in order. The pipeline consists of
// the three parallel 16-stage CORDIC pipelines (full joint angle, half joint
// angle, half twist angle) plus one fold stage, one sign stage, one multiply
// stage and one round/saturate stage that drives the outputs. A stall on the
// output while valid_o is high freezes the whole pipeline and raises stall_o
// in the same cycle; nothing is lost or repeated.
module dh_link_to_translation_quaternion import dhq_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [ANGLE_BITS-1:0]  joint_angle_i,
  input  logic signed [ANGLE_BITS-1:0]  twist_angle_i,
  input  logic signed [LENGTH_BITS-1:0] link_offset_i,
  input  logic signed [LENGTH_BITS-1:0] link_depth_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [LENGTH_BITS-1:0] trans_x_o,
  output logic signed [LENGTH_BITS-1:0] trans_y_o,
  output logic signed [LENGTH_BITS-1:0] trans_z_o,
  output logic signed [QUAT_BITS-1:0]   quat_w_o,
  output logic signed [QUAT_BITS-1:0]   quat_x_o,
  output logic signed [QUAT_BITS-1:0]   quat_y_o,
  output logic signed [QUAT_BITS-1:0]   quat_z_o
);

  logic                          adv;
  logic                          vld_q [TOTAL_LAT];
  logic signed [LENGTH_BITS-1:0] r_q   [CORDIC_LAT];
  logic signed [LENGTH_BITS-1:0] d_q   [TOTAL_LAT];
  logic signed [PHASE_BITS-1:0]  ph_theta, ph_half_theta, ph_half_alpha;
  logic signed [XY_BITS-1:0]     ct, st, cht, sht, cha, sha;

  assign adv     = !vld_q[TOTAL_LAT-1] || !stall_i;
  assign stall_o = !adv;
  assign valid_o = vld_q[TOTAL_LAT-1];

  // binary angles widened to a 2^32 phase circle
  assign ph_theta      = $signed({joint_angle_i[ANGLE_BITS-1], joint_angle_i,
                                  {(32-ANGLE_BITS){1'b0}}});
  assign ph_half_theta = $signed({{2{joint_angle_i[ANGLE_BITS-1]}}, joint_angle_i,
                                  {(31-ANGLE_BITS){1'b0}}});
  assign ph_half_alpha = $signed({{2{twist_angle_i[ANGLE_BITS-1]}}, twist_angle_i,
                                  {(31-ANGLE_BITS){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TOTAL_LAT; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < TOTAL_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0] <= link_offset_i;
      d_q[0] <= link_depth_i;
      for (int i = 1; i < CORDIC_LAT; i++) r_q[i] <= r_q[i-1];
      for (int i = 1; i < TOTAL_LAT; i++) d_q[i] <= d_q[i-1];
    end
  end

  dhq_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (ph_theta),
    .cos_o   (ct),
    .sin_o   (st)
  );

  dhq_cordic u_cordic_half_theta (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (ph_half_theta),
    .cos_o   (cht),
    .sin_o   (sht)
  );

  dhq_cordic u_cordic_half_alpha (
    .clk_i   (clk_i),
    .en_i    (adv),
    .phase_i (ph_half_alpha),
    .cos_o   (cha),
    .sin_o   (sha)
  );

  dhq_product u_product (
    .clk_i     (clk_i),
    .en_i      (adv),
    .r_i       (r_q[CORDIC_LAT-1]),
    .ct_i      (ct),
    .st_i      (st),
    .cht_i     (cht),
    .sht_i     (sht),
    .cha_i     (cha),
    .sha_i     (sha),
    .trans_x_o (trans_x_o),
    .trans_y_o (trans_y_o),
    .quat_w_o  (quat_w_o),
    .quat_x_o  (quat_x_o),
    .quat_y_o  (quat_y_o),
    .quat_z_o  (quat_z_o)
  );

  assign trans_z_o = d_q[TOTAL_LAT-1];

  // quaternion norm check, one is 2^(2*FRACTION_BITS)
  localparam logic signed [2*QUAT_BITS+1:0] NORM_ONE = (2*QUAT_BITS+2)'(1 << (2*FRACTION_BITS));
  localparam logic signed [2*QUAT_BITS+1:0] NORM_TOL = (2*QUAT_BITS+2)'(1 << (2*FRACTION_BITS-8));
  logic signed [2*QUAT_BITS+1:0] qnorm;

  assign qnorm = quat_w_o * quat_w_o + quat_x_o * quat_x_o
               + quat_y_o * quat_y_o + quat_z_o * quat_z_o;

  a_quat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quat_w_o <= QUAT_ONE) && (quat_w_o >= QUAT_NEG_ONE)
             && (quat_x_o <= QUAT_ONE) && (quat_x_o >= QUAT_NEG_ONE)
             && (quat_y_o <= QUAT_ONE) && (quat_y_o >= QUAT_NEG_ONE)
             && (quat_z_o <= QUAT_ONE) && (quat_z_o >= QUAT_NEG_ONE))
    else $error("quaternion component out of range");

  a_quat_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (qnorm < NORM_ONE + NORM_TOL) && (qnorm > NORM_ONE - NORM_TOL))
    else $error("quaternion not of unit length");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!vld_q[TOTAL_LAT-2] && !valid_o) |=> !valid_o)
    else $error("result transaction without a source");

endmodule
